// ----- design/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants for the double-ended queue
// Word storage depth, operation codes, transaction structs, controller states
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH   = 1024;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam int WORD_W  = 32;
  localparam int OP_W    = 3;
  localparam int ENTRY_W = 11;

  localparam logic [OP_W-1:0] OP_NONE       = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd4;

  localparam logic signed [WORD_W-1:0] MINUS_ONE = -32'sd1;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [WORD_W-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] popped_value;
    logic                     pop_failed;
    logic                     push_dropped;
    logic [ENTRY_W-1:0]       entry_count;
    logic                     is_empty;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] back_value;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH_FRONT,
    ST_FETCH_BACK,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic exec;
    logic load_front;
    logic load_back;
  } cmd_t;

  typedef struct packed {
    logic fetch_front;
    logic fetch_back;
  } sts_t;

  function automatic logic [ADDR_W-1:0] ring_next(input logic [ADDR_W-1:0] p);
    ring_next = (p == ADDR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] ring_prev(input logic [ADDR_W-1:0] p);
    ring_prev = (p == '0) ? ADDR_W'(DEPTH - 1) : p - 1'b1;
  endfunction

endpackage

// ----- design/deq_ctrl.sv -----
// ----------------------------------------------------------------------------
// deq_ctrl: transaction sequencer
// Accepts one request, waits for a store read when the new end word must be
// fetched, then holds the response until it is taken.
// ----------------------------------------------------------------------------
module deq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  input  deq_pkg::sts_t sts,
  output deq_pkg::cmd_t cmd
);
  import deq_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    req_stall      = 1'b1;
    rsp_valid      = 1'b0;
    case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.exec = 1'b1;
          if (sts.fetch_front) begin
            state_next = ST_FETCH_FRONT;
          end else if (sts.fetch_back) begin
            state_next = ST_FETCH_BACK;
          end else begin
            state_next = ST_OUT;
          end
        end
      end
      ST_FETCH_FRONT: begin
        cmd.load_front = 1'b1;
        state_next     = ST_OUT;
      end
      ST_FETCH_BACK: begin
        cmd.load_back = 1'b1;
        state_next    = ST_OUT;
      end
      ST_OUT: begin
        rsp_valid = 1'b1;
        if (!rsp_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/deq_dp.sv -----
// ----------------------------------------------------------------------------
// deq_dp: ring store, pointers, count and cached end words
// Front and back words live in registers; a pop that leaves words behind
// reads the new end word through the store's registered read port and loads it in a fetch state.
// ----------------------------------------------------------------------------
module deq_dp (
  input  logic          clk,
  input  logic          rst,
  input  deq_pkg::cmd_t cmd,
  input  deq_pkg::req_t req,
  output deq_pkg::sts_t sts,
  output deq_pkg::rsp_t rsp
);
  import deq_pkg::*;

  logic signed [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] rd_data;
  logic [ADDR_W-1:0]        head, tail;
  logic [COUNT_W-1:0]       count;
  logic signed [WORD_W-1:0] front, back, popped;
  logic                     pop_failed, push_dropped;

  logic              is_push_f, is_push_b, is_pop_f, is_pop_b;
  logic              full, empty, many;
  logic              mem_we;
  logic [ADDR_W-1:0] waddr, raddr, head_dec, tail_dec;

  always_comb begin
    is_push_f = (req.op == OP_PUSH_FRONT);
    is_push_b = (req.op == OP_PUSH_BACK);
    is_pop_f  = (req.op == OP_POP_FRONT);
    is_pop_b  = (req.op == OP_POP_BACK);
    full      = (count == COUNT_W'(DEPTH));
    empty     = (count == '0);
    many      = (count > COUNT_W'(1));
    head_dec  = ring_prev(head);
    tail_dec  = ring_prev(tail);
    mem_we    = cmd.exec && (is_push_f || is_push_b) && !full;
    waddr     = is_push_f ? head_dec : tail;
    raddr     = is_pop_f ? ring_next(head) : ring_prev(tail_dec);
    sts.fetch_front = is_pop_f && many;
    sts.fetch_back  = is_pop_b && many;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= req.push_value;
    end
    rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (cmd.exec) begin
      if ((is_push_f || is_push_b) && !full) begin
        count <= count + 1'b1;
        if (is_push_f) begin
          head <= head_dec;
        end else begin
          tail <= ring_next(tail);
        end
      end else if ((is_pop_f || is_pop_b) && !empty) begin
        count <= count - 1'b1;
        if (is_pop_f) begin
          head <= ring_next(head);
        end else begin
          tail <= tail_dec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      popped       <= MINUS_ONE;
      pop_failed   <= (is_pop_f || is_pop_b) && empty;
      push_dropped <= (is_push_f || is_push_b) && full;
      if ((is_push_f || is_push_b) && !full) begin
        if (is_push_f || empty) begin
          front <= req.push_value;
        end
        if (is_push_b || empty) begin
          back <= req.push_value;
        end
      end else if (is_pop_f && !empty) begin
        popped <= front;
      end else if (is_pop_b && !empty) begin
        popped <= back;
      end
    end
    if (cmd.load_front) begin
      front <= rd_data;
    end
    if (cmd.load_back) begin
      back <= rd_data;
    end
  end

  always_comb begin
    rsp.popped_value = popped;
    rsp.pop_failed   = pop_failed;
    rsp.push_dropped = push_dropped;
    rsp.entry_count  = ENTRY_W'(count);
    rsp.is_empty     = empty;
    rsp.front_value  = empty ? MINUS_ONE : front;
    rsp.back_value   = empty ? MINUS_ONE : back;
  end

endmodule

// ----- design/double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed 32-bit words
// Push or pop at either end of a ring store; each request returns one
// response with flags, count and the end words after the operation.
// ----------------------------------------------------------------------------
//   channel   valid       stall       payload
//   request   req_valid   req_stall   req (op, push_value)
//   response  rsp_valid   rsp_stall   rsp (popped_value .. back_value)
//
// One transaction at a time: the response is valid in ST_OUT, entered straight
// from accept, or through a fetch state when a pop leaves words behind (the new
// end word comes from the store's registered read port).
// The request side is stalled until the response is taken.
// Reset empties the queue; store contents are not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  deq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output deq_pkg::rsp_t rsp
);
  import deq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  deq_dp u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .sts (sts),
    .rsp (rsp)
  );

endmodule

// ----- verif/double_ended_queue_test.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue_test: self-checking bench for the ring deque
// Sends push, pop and query transactions at both ends with random idle
// bursts on both channels. It tracks its own copy of the deque and compares
// every response field with what that copy predicts. Pops on an empty queue
// and unknown op codes are also exercised.
// ----------------------------------------------------------------------------
module double_ended_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  double_ended_queue i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // shadow deque
  logic signed [WORD_W-1:0] shadow_words [DEPTH];
  logic [ADDR_W-1:0]        shadow_head = '0;
  logic [ADDR_W-1:0]        shadow_tail = '0;
  int unsigned              shadow_count = 0;

  req_t op_queue [$];
  rsp_t deque_outcomes [$];
  int   ops_loaded = 0;
  int   ops_taken = 0;
  int   rsp_seen = 0;
  int   mismatch_count = 0;
  bit   calm_tail = 1'b0;
  int   send_gap = 0;
  int   stall_left = 0;
  rsp_t next_want;

  function automatic logic [ADDR_W-1:0] wrap_down(input logic [ADDR_W-1:0] p);
    return ADDR_W'((int'(p) + DEPTH - 1) % DEPTH);
  endfunction

  function automatic logic [ADDR_W-1:0] wrap_up(input logic [ADDR_W-1:0] p);
    return ADDR_W'((int'(p) + 1) % DEPTH);
  endfunction

  task automatic apply_deque_op(input req_t item);
    rsp_t res;
    res = '0;
    res.popped_value = MINUS_ONE;
    case (item.op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (shadow_count == DEPTH) begin
          res.push_dropped = 1'b1;
        end else if (item.op == OP_PUSH_FRONT) begin
          shadow_head = wrap_down(shadow_head);
          shadow_words[shadow_head] = item.push_value;
          shadow_count++;
        end else begin
          shadow_words[shadow_tail] = item.push_value;
          shadow_tail = wrap_up(shadow_tail);
          shadow_count++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (shadow_count == 0) begin
          res.pop_failed = 1'b1;
        end else if (item.op == OP_POP_FRONT) begin
          res.popped_value = shadow_words[shadow_head];
          shadow_head = wrap_up(shadow_head);
          shadow_count--;
        end else begin
          shadow_tail = wrap_down(shadow_tail);
          res.popped_value = shadow_words[shadow_tail];
          shadow_count--;
        end
      end
      default: ;
    endcase
    res.entry_count = ENTRY_W'(shadow_count);
    res.is_empty    = (shadow_count == 0);
    res.front_value = (shadow_count == 0) ? MINUS_ONE : shadow_words[shadow_head];
    res.back_value  = (shadow_count == 0) ? MINUS_ONE : shadow_words[wrap_down(shadow_tail)];
    deque_outcomes.insert(deque_outcomes.size(), res);
  endtask

  task automatic note_mismatch(input string what);
    if (mismatch_count < 40) $display("mismatch: %s", what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] got,
                             input logic [WORD_W-1:0] want);
    if (got !== want)
      note_mismatch($sformatf("response %0d %s got %0h want %0h", rsp_seen, name, got, want));
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (req_valid && !req_stall) begin
        apply_deque_op(req);
        ops_taken++;
      end
      if (!req_valid || !req_stall) begin
        if (!calm_tail && send_gap > 0) begin
          req_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (op_queue.size() == 0) begin
          req_valid <= 1'b0;
        end else if (!calm_tail && $urandom_range(0, 11) == 0) begin
          req_valid <= 1'b0;
          send_gap <= $urandom_range(0, 14);
        end else begin
          req <= op_queue[0];
          op_queue.delete(0);
          req_valid <= 1'b1;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (deque_outcomes.size() == 0) begin
          note_mismatch($sformatf("response %0d arrived with none awaited", rsp_seen));
        end else begin
          next_want = deque_outcomes[0];
          deque_outcomes.delete(0);
          check_field("popped_value", rsp.popped_value, next_want.popped_value);
          check_field("pop_failed", WORD_W'(rsp.pop_failed), WORD_W'(next_want.pop_failed));
          check_field("push_dropped", WORD_W'(rsp.push_dropped),
                      WORD_W'(next_want.push_dropped));
          check_field("entry_count", WORD_W'(rsp.entry_count),
                      WORD_W'(next_want.entry_count));
          check_field("is_empty", WORD_W'(rsp.is_empty), WORD_W'(next_want.is_empty));
          check_field("front_value", rsp.front_value, next_want.front_value);
          check_field("back_value", rsp.back_value, next_want.back_value);
        end
        rsp_seen++;
      end
      if (!calm_tail && stall_left > 0) begin
        rsp_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (!calm_tail && $urandom_range(0, 11) == 0) begin
        rsp_stall <= 1'b1;
        stall_left <= $urandom_range(0, 14);
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  function automatic void queue_op(input logic [OP_W-1:0] op,
                                   input logic signed [WORD_W-1:0] value);
    req_t item;
    item.op = op;
    item.push_value = value;
    op_queue.insert(op_queue.size(), item);
    ops_loaded++;
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 19))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return MINUS_ONE;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_random_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)
      queue_op($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_word());
    else if (r < 88)
      queue_op($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, pick_word());
    else if (r < 93)
      queue_op(OP_NONE, pick_word());
    else
      queue_op(OP_W'($urandom_range(5, 7)), pick_word());
  endfunction

  task automatic wait_drained();
    while (ops_taken != ops_loaded || deque_outcomes.size() != 0 || req_valid)
      @(negedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty pops, extreme words, unknown ops, single-entry cases
    queue_op(OP_NONE, pick_word());
    queue_op(OP_POP_FRONT, pick_word());
    queue_op(OP_POP_BACK, pick_word());
    queue_op(OP_PUSH_FRONT, 32'sh7fffffff);
    queue_op(OP_PUSH_BACK, 32'sh80000000);
    queue_op(OP_PUSH_FRONT, MINUS_ONE);
    queue_op(OP_PUSH_BACK, '0);
    queue_op(3'd5, pick_word());
    queue_op(3'd6, pick_word());
    queue_op(3'd7, pick_word());
    queue_op(OP_PUSH_FRONT, 32'sd1);
    queue_op(OP_POP_BACK, pick_word());
    queue_op(OP_POP_FRONT, pick_word());
    queue_op(OP_POP_BACK, pick_word());
    queue_op(OP_POP_FRONT, pick_word());
    queue_op(OP_POP_FRONT, pick_word());
    queue_op(OP_POP_BACK, pick_word());
    queue_op(OP_PUSH_BACK, 32'sh55555555);
    queue_op(OP_POP_FRONT, pick_word());
    queue_op(OP_PUSH_FRONT, 32'shaaaaaaaa);
    queue_op(OP_POP_BACK, pick_word());
    queue_op(OP_NONE, pick_word());
    wait_drained();

    for (int i = 0; i < 360; i++) queue_random_op();
    wait_drained();

    calm_tail <= 1'b1;
    for (int i = 0; i < 70; i++) queue_random_op();
    wait_drained();

    repeat (10) @(posedge clk);
    if (deque_outcomes.size() != 0) note_mismatch("responses still awaited at end");
    if (mismatch_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- double_ended_queue.f -----
design/deq_pkg.sv
design/deq_ctrl.sv
design/deq_dp.sv
design/double_ended_queue.sv
verif/double_ended_queue_test.sv
